FILE: hw/rtl/ctc_pkg.sv
// shared types, register indexes and constants for the color threshold centroid block
// no dependencies; imported by ctc_front, ctc_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 21;
  localparam int CENT_W     = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_BOUNDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CB_BOUNDS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_BOUNDS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SHAPE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_MATCHES = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_OUTLINE = 3'd7;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd240;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd520;

  localparam logic [7:0] LUMA_MAX = 8'd255;
  // trapezoid margin at the left edge
  localparam logic [6:0] TRAP_EDGE = 7'd80;
  // ceil(2^20 / 20): exact floor(v/20) for v below 2^15
  localparam logic [15:0] RECIP_20    = 16'd52429;
  localparam int          RECIP_SHIFT = 20;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_chroma;
    logic [7:0] red_chroma;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]                luma_out;
    logic                      frame_done;
    logic [COUNT_W-1:0]        match_count;
    logic signed [CENT_W-1:0]  centroid_x;
    logic signed [CENT_W-1:0]  centroid_y;
  } pix_out_t;

  // classified pixel passed from front to back
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       in_roi;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [15:0] luma_bounds;
    logic [15:0] cb_bounds;
    logic [15:0] cr_bounds;
    logic        mark_matches;
  } thr_cfg_t;

  function automatic logic in_range(logic [7:0] v, logic [15:0] b);
    return (v >= b[7:0]) && (v <= b[15:8]);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ctc_div.sv
// restoring divider, one quotient bit per cycle
// no package dependencies; used by ctc_front and ctc_back
`timescale 1ns / 1ps
`default_nettype none

module ctc_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int CNTB = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [CNTB-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_sub;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CNTB'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[NW-2:0], ge};
        rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTB'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // a new division never starts over a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: hw/rtl/ctc_front.sv
// front part: pixel intake, column and row counting, region classification
// depends on ctc_pkg and ctc_div
`timescale 1ns / 1ps
`default_nettype none

module ctc_front import ctc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire pix_in_t       in_data_i,
  output logic               in_stall_o,
  input  wire logic [WW-1:0] w_i,
  input  wire logic [HW-1:0] h_i,
  input  wire logic          shape_i,
  input  wire logic          force_outline_i,
  input  wire logic          full_i,
  output logic               push_o,
  output cls_t               push_data_o,
  output logic [XW-1:0]      push_x_o,
  output logic [YW-1:0]      push_y_o
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_GEOM = 3'd1;
  localparam logic [2:0] F_CLS  = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_TRAP = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  localparam int PRW = WW + 19;
  localparam int NTW = XW + HW + 8;
  localparam int NW  = NTW + 2;
  localparam int DW  = XW + 1;
  localparam int SW  = HW + 9;

  logic [2:0]    state_q;
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  pix_in_t       pix_q;
  logic [XW-1:0] c_q;
  logic [XW-1:0] xmin_q;
  logic [NTW-1:0] n_q;
  logic          inside_q;
  logic          outline_q;
  logic          div_start_q;

  logic [WW+2:0]  w7, w8;
  logic [PRW-1:0] prod_c, prod_x;
  logic [XW-1:0]  cmx;
  logic [HW-1:0]  quarter_h;
  logic [HW+XW-1:0] mx;
  logic [NTW-1:0] n_d;
  logic [HW+1:0]  h3;
  logic [WW-1:0]  x_w, wm1;
  logic [HW+1:0]  y_h, rymin, rymax;
  logic           in_x, in_y, rect_in, rect_out;
  logic           trap_skip;
  logic           div_done;
  logic [NW-1:0]  quo;
  logic [NW-1:0]  div_num;
  logic [SW+XW-1:0] tie_prod;
  logic           tie, ymax_up;
  logic signed [SW-1:0] ymin_s, ymax_s, y_s;
  logic           trap_in, trap_out;
  logic           last_col, last_row;

  ctc_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num),
    .den_i  ({c_q, 1'b0}),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // region geometry
  always_comb begin
    w7        = ({3'b000, w_i} << 3) - {3'b000, w_i};
    w8        = {w_i, 3'b000};
    prod_c    = PRW'(w7) * PRW'(RECIP_20);
    prod_x    = PRW'(w8) * PRW'(RECIP_20);
    cmx       = c_q - x_q;
    quarter_h = h_i >> 2;
    mx        = {{XW{1'b0}}, quarter_h} * {{HW{1'b0}}, x_q};
    n_d       = (NTW'(cmx) << 6) + (NTW'(cmx) << 4) + NTW'(mx);
    div_num   = NW'({n_q, 1'b0}) + NW'(c_q);
    // rectangle
    h3        = {2'b00, h_i} + {1'b0, h_i, 1'b0};
    x_w       = WW'(x_q);
    wm1       = w_i - 1'b1;
    y_h       = (HW+2)'(y_q);
    rymin     = (HW+2)'(quarter_h);
    rymax     = h3 >> 2;
    in_x      = (x_w >= WW'(xmin_q)) && (x_w <= wm1);
    in_y      = (y_h >= rymin) && (y_h <= rymax);
    rect_in   = in_x && in_y;
    rect_out  = (((x_w == WW'(xmin_q)) || (x_w == wm1)) && in_y) ||
                (((y_h == rymin) || (y_h == rymax)) && in_x);
    trap_skip = (c_q == '0) || (x_q > c_q);
    // trapezoid from the rounded margin
    ymin_s    = $signed({1'b0, quo[SW-2:0]});
    // margin exactly half way: the far edge h - m rounds up when still positive
    tie_prod  = (SW+XW)'(quo[SW-2:0]) * (SW+XW)'({c_q, 1'b0});
    tie       = NW'(tie_prod) == div_num;
    ymax_up   = tie && (ymin_s <= $signed(SW'(h_i)));
    ymax_s    = $signed(SW'(h_i)) - ymin_s + $signed(SW'(ymax_up));
    y_s       = $signed(SW'(y_q));
    trap_in   = (y_s >= ymin_s) && (y_s <= ymax_s);
    trap_out  = (((x_q == '0) || (x_q == c_q)) && trap_in) ||
                (y_s == ymin_s) || (y_s == ymin_s + 1) || (y_s + 1 == ymin_s) ||
                (y_s == ymax_s) || (y_s == ymax_s + 1) || (y_s + 1 == ymax_s);
    last_col  = x_w >= wm1;
    last_row  = HW'(y_q) >= (h_i - 1'b1);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      pix_q       <= '0;
      c_q         <= '0;
      xmin_q      <= '0;
      n_q         <= '0;
      inside_q    <= 1'b0;
      outline_q   <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            pix_q   <= in_data_i;
            x_q     <= col_q;
            y_q     <= row_q;
            state_q <= F_GEOM;
          end
        end
        F_GEOM: begin
          c_q     <= XW'(prod_c >> RECIP_SHIFT);
          xmin_q  <= XW'(prod_x >> RECIP_SHIFT);
          state_q <= F_CLS;
        end
        F_CLS: begin
          if (shape_i) begin
            inside_q  <= rect_in;
            outline_q <= rect_out;
            state_q   <= F_PUSH;
          end else if (trap_skip) begin
            inside_q  <= 1'b0;
            outline_q <= 1'b0;
            state_q   <= F_PUSH;
          end else begin
            n_q         <= n_d;
            div_start_q <= 1'b1;
            state_q     <= F_DIV;
          end
        end
        F_DIV: begin
          if (div_done) begin
            state_q <= F_TRAP;
          end
        end
        F_TRAP: begin
          inside_q  <= trap_in;
          outline_q <= trap_out;
          state_q   <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) begin
            if (last_col && last_row) begin
              col_q <= '0;
              row_q <= '0;
            end else if (last_col) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o = state_q != F_IDLE;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  // outline forcing happens before thresholding
  always_comb begin
    push_data_o.luma   = (force_outline_i && outline_q) ? LUMA_MAX : pix_q.luma;
    push_data_o.cb     = pix_q.blue_chroma;
    push_data_o.cr     = pix_q.red_chroma;
    push_data_o.in_roi = inside_q;
    push_data_o.last   = last_col && last_row;
  end

  assign push_x_o = x_q;
  assign push_y_o = y_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ctc_queue.sv
// two-entry queue between the front and back parts
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module ctc_queue #(
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  input  wire logic          pop_i,
  output logic [DW-1:0]      data_o,
  output logic               valid_o,
  output logic               full_o
);

  localparam int DEPTH = 2;
  localparam int PTRW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [PTRW-1:0] wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign data_o  = mem_q[rd_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CNTW'(DEPTH);

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hw/rtl/ctc_back.sv
// back part: thresholding, match accumulation, frame-end centroid, output register
// depends on ctc_pkg and ctc_div
`timescale 1ns / 1ps
`default_nettype none

module ctc_back import ctc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire cls_t          q_data_i,
  input  wire logic [XW-1:0] q_x_i,
  input  wire logic [YW-1:0] q_y_i,
  output logic               pop_o,
  input  wire thr_cfg_t      thr_i,
  input  wire logic [WW-1:0] w_i,
  input  wire logic [HW-1:0] h_i,
  output logic               out_valid_o,
  output pix_out_t           out_data_o,
  input  wire logic          out_stall_i
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_SETX = 3'd2;
  localparam logic [2:0] B_DIVX = 3'd3;
  localparam logic [2:0] B_SETY = 3'd4;
  localparam logic [2:0] B_DIVY = 3'd5;

  localparam int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUMXW = CNTW + XW;
  localparam int SUMYW = CNTW + YW;
  localparam int PW    = CNTW + WW + HW + 2;
  localparam int DNW   = PW + 2;
  localparam int DDW   = CNTW + 2;

  logic [2:0]         state_q;
  logic [CNTW-1:0]    cnt_q, fn_q;
  logic [SUMXW-1:0]   sx_q, fsx_q;
  logic [SUMYW-1:0]   sy_q, fsy_q;
  logic [7:0]         luma_q;
  logic [WW+CNTW-1:0] wn_q;
  logic [HW+CNTW-1:0] hn_q;
  logic               neg_q;
  logic [CENT_W-1:0]  cx_q;
  logic               div_start_q;
  logic [DNW-1:0]     div_num_q;
  logic [DDW-1:0]     div_den_q;
  logic               out_valid_q;
  pix_out_t           out_q;

  logic               match;
  logic [7:0]         luma_o;
  logic [CNTW-1:0]    cnt_new;
  logic [SUMXW-1:0]   sx_new;
  logic [SUMYW-1:0]   sy_new;
  logic signed [PW-1:0] numx, numy;
  logic [PW-1:0]      magx, magy;
  logic               div_done;
  logic [DNW-1:0]     quo;
  logic [CENT_W-1:0]  cent;

  ctc_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // threshold and running sums
  always_comb begin
    match   = q_data_i.in_roi && in_range(q_data_i.luma, thr_i.luma_bounds) &&
              in_range(q_data_i.cb, thr_i.cb_bounds) &&
              in_range(q_data_i.cr, thr_i.cr_bounds);
    luma_o  = (match && thr_i.mark_matches) ? LUMA_MAX : q_data_i.luma;
    cnt_new = cnt_q + CNTW'(match);
    sx_new  = sx_q + (match ? SUMXW'(q_x_i) : '0);
    sy_new  = sy_q + (match ? SUMYW'(q_y_i) : '0);
    pop_o   = (state_q == B_IDLE) && q_valid_i && !out_valid_q;
  end

  // centroid numerators, signed, and their magnitudes
  always_comb begin
    numx = $signed(PW'({fsx_q, 1'b0})) - $signed(PW'(wn_q));
    numy = $signed(PW'(hn_q)) - $signed(PW'({fsy_q, 1'b0}));
    magx = numx[PW-1] ? PW'(-numx) : PW'(numx);
    magy = numy[PW-1] ? PW'(-numy) : PW'(numy);
    cent = neg_q ? CENT_W'(DNW'(0) - quo) : CENT_W'(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      fn_q        <= '0;
      fsx_q       <= '0;
      fsy_q       <= '0;
      luma_q      <= '0;
      wn_q        <= '0;
      hn_q        <= '0;
      neg_q       <= 1'b0;
      cx_q        <= '0;
      div_start_q <= 1'b0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (!q_data_i.last) begin
              cnt_q       <= cnt_new;
              sx_q        <= sx_new;
              sy_q        <= sy_new;
              out_q       <= '{luma_out: luma_o, frame_done: 1'b0, match_count: '0,
                               centroid_x: '0, centroid_y: '0};
              out_valid_q <= 1'b1;
            end else begin
              cnt_q  <= '0;
              sx_q   <= '0;
              sy_q   <= '0;
              fn_q   <= cnt_new;
              fsx_q  <= sx_new;
              fsy_q  <= sy_new;
              luma_q <= luma_o;
              if (cnt_new == '0) begin
                out_q       <= '{luma_out: luma_o, frame_done: 1'b1, match_count: '0,
                                 centroid_x: '0, centroid_y: '0};
                out_valid_q <= 1'b1;
              end else begin
                state_q <= B_MUL;
              end
            end
          end
        end
        B_MUL: begin
          wn_q    <= {{CNTW{1'b0}}, w_i} * {{WW{1'b0}}, fn_q};
          hn_q    <= {{CNTW{1'b0}}, h_i} * {{HW{1'b0}}, fn_q};
          state_q <= B_SETX;
        end
        B_SETX: begin
          neg_q       <= numx[PW-1];
          div_num_q   <= DNW'({magx, 1'b0}) + DNW'({fn_q, 1'b0});
          div_den_q   <= {fn_q, 2'b00};
          div_start_q <= 1'b1;
          state_q     <= B_DIVX;
        end
        B_DIVX: begin
          if (div_done) begin
            cx_q    <= cent;
            state_q <= B_SETY;
          end
        end
        B_SETY: begin
          neg_q       <= numy[PW-1];
          div_num_q   <= DNW'({magy, 1'b0}) + DNW'({fn_q, 1'b0});
          div_den_q   <= {fn_q, 2'b00};
          div_start_q <= 1'b1;
          state_q     <= B_DIVY;
        end
        B_DIVY: begin
          if (div_done) begin
            out_q       <= '{luma_out: luma_q, frame_done: 1'b1,
                             match_count: COUNT_W'(fn_q),
                             centroid_x: cx_q, centroid_y: cent};
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // summary fields stay zero except on the last pixel of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_done) |->
    (out_q.match_count == '0 && out_q.centroid_x == '0 && out_q.centroid_y == '0))
    else $error("frame summary outside frame end");

endmodule

`default_nettype wire

FILE: hw/rtl/color_threshold_centroid.sv
// top level: configuration registers, front classifier, queue and back accumulator
// depends on ctc_pkg, ctc_front, ctc_queue, ctc_back (ctc_div below them)
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------
//   pixel in | in_valid_i / in_stall_o   | in_data_i  (pix_in_t)
//   pixel out| out_valid_o / out_stall_i | out_data_o (pix_out_t)
//   config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// rectangle pixels pass the front through the intake, geometry, classify and push states;
// trapezoid pixels inside the margin span also wait in the divide and trapezoid states
// for the bit-serial margin divider. the back pops a new beat only once the output
// register has emptied; at a frame end with matches it runs the multiply state, then setup
// and a serial division for x, then setup and a serial division for y.
// a two-entry queue lets the front keep classifying while the output beat is stalled.
// reset is asynchronous active low; no memory clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module color_threshold_centroid import ctc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire pix_in_t               in_data_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  output pix_out_t                   out_data_o,
  input  wire logic                  out_stall_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int QW = $bits(cls_t) + XW + YW;

  logic [15:0]       luma_bounds_q, cb_bounds_q, cr_bounds_q;
  logic [SIZE_W-1:0] frame_width_q, frame_height_q;
  logic              region_shape_q, mark_matches_q, mark_outline_q;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  thr_cfg_t      thr;

  logic          push, pop, q_full, q_valid;
  cls_t          push_data, pop_data;
  logic [XW-1:0] push_x, pop_x;
  logic [YW-1:0] push_y, pop_y;
  logic [QW-1:0] q_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_bounds_q  <= '0;
      cb_bounds_q    <= '0;
      cr_bounds_q    <= '0;
      frame_width_q  <= RESET_WIDTH;
      frame_height_q <= RESET_HEIGHT;
      region_shape_q <= 1'b0;
      mark_matches_q <= 1'b0;
      mark_outline_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LUMA_BOUNDS:  luma_bounds_q  <= cfg_data_i;
        CFG_CB_BOUNDS:    cb_bounds_q    <= cfg_data_i;
        CFG_CR_BOUNDS:    cr_bounds_q    <= cfg_data_i;
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_REGION_SHAPE: region_shape_q <= cfg_data_i[0];
        CFG_MARK_MATCHES: mark_matches_q <= cfg_data_i[0];
        CFG_MARK_OUTLINE: mark_outline_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // effective frame size: zero acts as one, large values saturate
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_q);
    end
    thr.luma_bounds  = luma_bounds_q;
    thr.cb_bounds    = cb_bounds_q;
    thr.cr_bounds    = cr_bounds_q;
    thr.mark_matches = mark_matches_q;
  end

  ctc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .in_stall_o     (in_stall_o),
    .w_i            (w_eff),
    .h_i            (h_eff),
    .shape_i        (region_shape_q),
    .force_outline_i(mark_matches_q && mark_outline_q),
    .full_i         (q_full),
    .push_o         (push),
    .push_data_o    (push_data),
    .push_x_o       (push_x),
    .push_y_o       (push_y)
  );

  ctc_queue #(.DW(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_data, push_x, push_y}),
    .pop_i  (pop),
    .data_o (q_out),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  assign {pop_data, pop_x, pop_y} = q_out;

  ctc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_x_i      (pop_x),
    .q_y_i      (pop_y),
    .pop_o      (pop),
    .thr_i      (thr),
    .w_i        (w_eff),
    .h_i        (h_eff),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for color_threshold_centroid: directed and random pixel frames
// depends on ctc_pkg and the color_threshold_centroid rtl; carries its own pixel predictor
`timescale 1ns / 1ps

module testbench;
  import ctc_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  pix_in_t               in_data;
  logic                  in_stall;
  logic                  out_valid;
  pix_out_t              out_data;
  logic                  out_stall;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  color_threshold_centroid DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_data_o (out_data),
    .out_stall_i(out_stall),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow registers
  logic [15:0] y_bnd, cb_bnd, cr_bnd;
  logic [10:0] fw, fh;
  logic        shape_rect, draw_on, draw_rim;

  // shadow counters and sums
  longint col_pos, row_pos, hits, col_acc, row_acc;

  pix_in_t  pending_pixels[$];
  pix_out_t expected_results[$];
  int       errors;
  bit       quiet;
  logic     in_took;
  int       in_gap, out_hold;

  // half away from zero
  function automatic longint div_round(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic longint clamp_size(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return longint'(v);
  endfunction

  function automatic bit fits(logic [7:0] v, logic [15:0] b);
    return v >= b[7:0] && v <= b[15:8];
  endfunction

  // expected output beat for one pixel, advancing the shadow counters
  function automatic pix_out_t next_pixel_result(pix_in_t p);
    pix_out_t r;
    longint w, h, c, me, n, lo, hi, xmin;
    bit ins, rim;
    logic [7:0] y;
    w = clamp_size(fw);
    h = clamp_size(fh);
    ins = 0;
    rim = 0;
    y = p.luma;
    if (!shape_rect) begin
      c = (7 * w) / 20;
      me = h / 4;
      if (c > 0 && col_pos <= c) begin
        n = 80 * (c - col_pos) + me * col_pos;
        lo = div_round(n, c);
        hi = div_round(h * c - n, c);
        ins = row_pos >= lo && row_pos <= hi;
        if ((col_pos == 0 || col_pos == c) && ins) rim = 1;
        if ((row_pos - lo <= 1 && lo - row_pos <= 1) ||
            (row_pos - hi <= 1 && hi - row_pos <= 1)) rim = 1;
      end
    end else begin
      xmin = (2 * w) / 5;
      lo = h / 4;
      hi = (3 * h) / 4;
      ins = col_pos >= xmin && col_pos <= w - 1 && row_pos >= lo && row_pos <= hi;
      rim = ((col_pos == xmin || col_pos == w - 1) && row_pos >= lo && row_pos <= hi) ||
            ((row_pos == lo || row_pos == hi) && col_pos >= xmin && col_pos <= w - 1);
    end
    // outline marking happens before thresholding
    if (draw_on && draw_rim && rim) y = LUMA_MAX;
    if (ins && fits(y, y_bnd) && fits(p.blue_chroma, cb_bnd) && fits(p.red_chroma, cr_bnd))
    begin
      hits++;
      col_acc += col_pos;
      row_acc += row_pos;
      if (draw_on) y = LUMA_MAX;
    end
    r = '0;
    r.luma_out = y;
    if (col_pos >= w - 1 && row_pos >= h - 1) begin
      r.frame_done = 1'b1;
      r.match_count = COUNT_W'(hits);
      if (hits > 0) begin
        r.centroid_x = CENT_W'(div_round(2 * col_acc - w * hits, 2 * hits));
        r.centroid_y = CENT_W'(div_round(h * hits - 2 * row_acc, 2 * hits));
      end
      col_pos = 0;
      row_pos = 0;
      hits = 0;
      col_acc = 0;
      row_acc = 0;
    end else if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // pixel driver and output stall, changed on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_data <= pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_hold <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin
    pix_out_t want;
    in_took <= in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) expected_results.push_back(next_pixel_result(in_data));
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("output beat with no pixel outstanding");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.luma_out !== want.luma_out) begin
          $error("luma_out expected %0d got %0d", want.luma_out, out_data.luma_out);
          errors++;
        end
        if (out_data.frame_done !== want.frame_done) begin
          $error("frame_done expected %0d got %0d", want.frame_done, out_data.frame_done);
          errors++;
        end
        if (out_data.match_count !== want.match_count) begin
          $error("match_count expected %0d got %0d", want.match_count, out_data.match_count);
          errors++;
        end
        if (out_data.centroid_x !== want.centroid_x) begin
          $error("centroid_x expected %0d got %0d", want.centroid_x, out_data.centroid_x);
          errors++;
        end
        if (out_data.centroid_y !== want.centroid_y) begin
          $error("centroid_y expected %0d got %0d", want.centroid_y, out_data.centroid_y);
          errors++;
        end
      end
    end
  end

  // write all registers while idle, one per cycle
  task automatic set_regs(logic [15:0] yb, logic [15:0] cbb, logic [15:0] crb,
                          logic [10:0] w, logic [10:0] h, bit rect, bit mm, bit mo);
    logic [15:0] vals[8];
    logic [CFG_IDX_W-1:0] idxs[8];
    vals = '{yb, cbb, crb, 16'(w), 16'(h), 16'(rect), 16'(mm), 16'(mo)};
    idxs = '{CFG_LUMA_BOUNDS, CFG_CB_BOUNDS, CFG_CR_BOUNDS, CFG_FRAME_WIDTH,
             CFG_FRAME_HEIGHT, CFG_REGION_SHAPE, CFG_MARK_MATCHES, CFG_MARK_OUTLINE};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= idxs[i];
      cfg_data <= vals[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    y_bnd = yb;
    cb_bnd = cbb;
    cr_bnd = crb;
    fw = w;
    fh = h;
    shape_rect = rect;
    draw_on = mm;
    draw_rim = mo;
  endtask

  // sender pauses until every pixel has come back, then lets the frame-end math settle
  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic push_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    pix_in_t p;
    p.luma = y;
    p.blue_chroma = cb;
    p.red_chroma = cr;
    pending_pixels.push_back(p);
  endtask

  task automatic push_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) push_pixel(8'hff, 8'hff, 8'hff);
      else if (r == 1) push_pixel(8'h00, 8'h00, 8'h00);
      else push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  function automatic logic [15:0] rand_bounds();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return {8'($urandom_range(150, 255)), 8'($urandom_range(0, 90))};
  endfunction

  // stimulus
  initial begin
    int sent, w, h, n;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_LUMA_BOUNDS;
    cfg_data = '0;
    in_took = 1'b0;
    in_gap = 0;
    out_hold = 0;
    errors = 0;
    quiet = 0;
    y_bnd = '0;
    cb_bnd = '0;
    cr_bnd = '0;
    fw = RESET_WIDTH;
    fh = RESET_HEIGHT;
    shape_rect = 0;
    draw_on = 0;
    draw_rim = 0;
    col_pos = 0;
    row_pos = 0;
    hits = 0;
    col_acc = 0;
    row_acc = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero sizes act as one pixel frames; trapezoid degenerate, then rectangle
    set_regs(16'hff00, 16'hff00, 16'hff00, 11'd0, 11'd0, 0, 1, 1);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff);
    drain();
    set_regs(16'hff00, 16'hff00, 16'hff00, 11'd0, 11'd0, 1, 1, 1);
    push_pixel(8'h55, 8'haa, 8'h0f);
    push_pixel(8'haa, 8'h55, 8'hf0);
    drain();

    // oversized frame, then shrink mid-row so the row and frame end early
    set_regs(16'hff00, 16'hff00, 16'hff00, 11'd2047, 11'd2047, 1, 0, 0);
    push_random(5);
    drain();
    set_regs(16'hff00, 16'hff00, 16'hff00, 11'd2, 11'd1, 1, 0, 0);
    push_random(3);
    drain();

    // outline forced to full luma is then thresholded as full luma
    set_regs(16'hffff, 16'hff00, 16'hff00, 11'd4, 11'd2, 1, 1, 1);
    push_random(8);
    drain();

    // empty bounds: nothing matches
    set_regs(16'h00ff, 16'hff00, 16'h10ff, 11'd4, 11'd2, 1, 1, 0);
    push_random(8);
    drain();

    // tall narrow trapezoid with interior and outline rows
    set_regs(16'hff00, rand_bounds(), rand_bounds(), 11'd3, 11'd90, 0, 1, 1);
    push_random(270);
    drain();

    // random frames, some partial so sizes change mid-frame
    sent = 0;
    while (sent < 330) begin
      quiet = $urandom_range(0, 4) == 0;
      w = $urandom_range(0, 12);
      h = $urandom_range(0, 10);
      set_regs(rand_bounds(), rand_bounds(), rand_bounds(), 11'(w), 11'(h),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
      n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      push_random(n);
      sent += n;
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard limit on run length
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_div.sv
hw/rtl/ctc_front.sv
hw/rtl/ctc_queue.sv
hw/rtl/ctc_back.sv
hw/rtl/color_threshold_centroid.sv
tb/testbench.sv
